// ===== hw/rtl/argb_pixel_alpha_composite_top_defines.svh =====
// assertion macros for the argb pixel composite checker
// expects clk and rst_n in the scope where a macro is used
`ifndef ARGB_PIXEL_ALPHA_COMPOSITE_TOP_DEFINES_SVH
`define ARGB_PIXEL_ALPHA_COMPOSITE_TOP_DEFINES_SVH

// same-cycle or sequence implication, disabled in reset
`define APAC_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("apac assertion failed");

// next-cycle implication, disabled in reset
`define APAC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("apac assertion failed");

`endif

// ===== hw/rtl/apac_pkg.sv =====
// types and constants for the argb pixel alpha composite block
// no dependencies
package apac_pkg;

    localparam int CH_N        = 3;
    localparam int CH_W        = 8;
    localparam int NUM_W       = 17;
    localparam int QUO_W       = 8;
    localparam int DIV_BITS    = 2;
    localparam int DIV_STAGES  = QUO_W / DIV_BITS;
    localparam int PIPE_LATENCY = DIV_STAGES + 4;
    localparam int CFG_INDEX_W = 2;

    localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_HAS_ALPHA = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_BLEND_ENABLE     = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_BLEND_FORMULA    = 2'd2;

    localparam logic [CH_W-1:0] ALPHA_OPAQUE  = 8'd255;
    localparam logic [CH_W-1:0] DST_ALPHA_MIN = 8'd5;
    localparam logic [CH_W-1:0] SRC_ALPHA_MAX = 8'd250;

    typedef enum logic [1:0] {
        MODE_PACK,
        MODE_OVER,
        MODE_SHIFT
    } mode_t;

endpackage

// ===== hw/rtl/argb_pixel_alpha_composite_top.sv =====
// argb8888 alpha composite: one source pixel over one destination word per item
// depends on apac_pkg
//
// usage: drive src_red/green/blue/alpha and dst_pixel with start high; the item
// is taken at an edge where start is high and busy is low. busy is high only
// during reset and until the edge after it is released, so an item may be given on
// every clock after that.
// config: cfg_we, cfg_index, cfg_data write source_has_alpha (0), blend_enable
// (1) and blend_formula (2); other indexes are ignored. write only while idle.
// the mode is sampled when the item is taken.
// result: out_pixel is valid for one cycle with done high. an item takes the
// same path through every stage of the pipe, for every mode.
// throughput: one item per clock. the depth is set by the over-blend divider,
// a restoring divider that retires two quotient bits per stage over four
// stages, behind three stages of select, multiply and sum.
// reset clears the valid bits and the config registers (source_has_alpha = 1).
// the receiver cannot stall, so nothing ever waits inside the pipe.
module argb_pixel_alpha_composite_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [7:0]  src_red,
    input  logic [7:0]  src_green,
    input  logic [7:0]  src_blue,
    input  logic [7:0]  src_alpha,
    input  logic [31:0] dst_pixel,
    output logic        done,
    output logic [31:0] out_pixel,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic        cfg_data
);
    import apac_pkg::*;

    logic has_alpha_reg;
    logic blend_en_reg;
    logic formula_reg;
    logic busy_reg;
    logic accept;

    // stage 1: captured item and mode
    logic            v1_reg;
    mode_t           mode1_reg;
    mode_t           mode1_next;
    logic [CH_W-1:0] a1_reg;
    logic [CH_W-1:0] a1_next;
    logic [CH_W-1:0] src1_reg [CH_N];
    logic [31:0]     dst1_reg;

    // stage 2: dst weight and shift blend
    logic            v2_reg;
    logic            over2_reg;
    logic [31:0]     early2_reg;
    logic [31:0]     early2_next;
    logic [CH_W-1:0] ad2_reg;
    logic [CH_W-1:0] ad2_next;
    logic [CH_W-1:0] sa2_reg;
    logic [CH_W-1:0] src2_reg [CH_N];
    logic [CH_W-1:0] dch2_reg [CH_N];
    logic [CH_W-1:0] da1;
    logic [15:0]     ad_prod;
    logic [CH_W-1:0] shift_ch [CH_N];

    // stage 3 and divider stages share indexed arrays, index 0 is stage 3
    logic            dv_reg    [DIV_STAGES+1];
    logic            dover_reg [DIV_STAGES+1];
    logic [31:0]     dearly_reg[DIV_STAGES+1];
    logic [CH_W-1:0] da0_reg   [DIV_STAGES+1];
    logic [NUM_W-1:0] drem_reg [DIV_STAGES+1][CH_N];
    logic [QUO_W-1:0] dquo_reg [DIV_STAGES+1][CH_N];
    logic [NUM_W-1:0] num3_next[CH_N];
    logic [8:0]       a0_sum;

    logic        done_reg;
    logic [31:0] out_pixel_reg;
    logic [31:0] out_pixel_next;

    assign accept = start && !busy_reg;
    assign busy   = busy_reg;

    // config registers and ready
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            has_alpha_reg <= 1'b1;
            blend_en_reg  <= 1'b0;
            formula_reg   <= 1'b0;
            busy_reg      <= 1'b1;
        end
        else
        begin
            busy_reg <= 1'b0;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_SOURCE_HAS_ALPHA: has_alpha_reg <= cfg_data;
                    REG_BLEND_ENABLE:     blend_en_reg  <= cfg_data;
                    REG_BLEND_FORMULA:    formula_reg   <= cfg_data;
                    default:              ;
                endcase
            end
        end
    end

    // mode select at the input
    always_comb
    begin
        a1_next = has_alpha_reg ? src_alpha : ALPHA_OPAQUE;
        if (!has_alpha_reg || !blend_en_reg || (dst_pixel[31:24] < DST_ALPHA_MIN)
            || (src_alpha > SRC_ALPHA_MAX))
        begin
            mode1_next = MODE_PACK;
        end
        else if (formula_reg)
        begin
            mode1_next = MODE_SHIFT;
        end
        else
        begin
            mode1_next = MODE_OVER;
        end
    end

    // stage 2 logic
    always_comb
    begin
        da1      = dst1_reg[31:24];
        ad_prod  = da1 * (ALPHA_OPAQUE - a1_reg);
        ad2_next = ad_prod[15:8];
        for (int c = 0; c < CH_N; c++)
        begin
            logic [16:0] sum;
            sum = 17'(dst1_reg[(CH_N-1-c)*CH_W +: CH_W] * da1)
                + 17'(src1_reg[c] * (ALPHA_OPAQUE - da1));
            shift_ch[c] = sum[15:8];
        end
        if (mode1_reg == MODE_SHIFT)
        begin
            early2_next = {a1_reg, shift_ch[0], shift_ch[1], shift_ch[2]};
        end
        else
        begin
            early2_next = {a1_reg, src1_reg[0], src1_reg[1], src1_reg[2]};
        end
    end

    // stage 3 logic: combined alpha and over numerators
    always_comb
    begin
        a0_sum = {1'b0, sa2_reg} + {1'b0, ad2_reg};
        for (int c = 0; c < CH_N; c++)
        begin
            num3_next[c] = NUM_W'(src2_reg[c] * sa2_reg) + NUM_W'(dch2_reg[c] * ad2_reg);
        end
    end

    // valid bits of the front stages and output
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            dv_reg[0] <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            v1_reg    <= accept;
            v2_reg    <= v1_reg;
            dv_reg[0] <= v2_reg;
            done_reg  <= dv_reg[DIV_STAGES];
        end
    end

    // payload of the front stages
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode1_reg   <= mode1_next;
            a1_reg      <= a1_next;
            src1_reg[0] <= src_red;
            src1_reg[1] <= src_green;
            src1_reg[2] <= src_blue;
            dst1_reg    <= dst_pixel;
        end
        if (v1_reg)
        begin
            over2_reg  <= (mode1_reg == MODE_OVER);
            early2_reg <= early2_next;
            ad2_reg    <= ad2_next;
            sa2_reg    <= a1_reg;
            for (int c = 0; c < CH_N; c++)
            begin
                src2_reg[c] <= src1_reg[c];
                dch2_reg[c] <= dst1_reg[(CH_N-1-c)*CH_W +: CH_W];
            end
        end
        if (v2_reg)
        begin
            dover_reg[0]  <= over2_reg;
            dearly_reg[0] <= early2_reg;
            da0_reg[0]    <= a0_sum[7:0];
            for (int c = 0; c < CH_N; c++)
            begin
                drem_reg[0][c] <= num3_next[c];
                dquo_reg[0][c] <= '0;
            end
        end
        if (dv_reg[DIV_STAGES])
        begin
            out_pixel_reg <= out_pixel_next;
        end
    end

    // restoring divider, two quotient bits per stage, msb first
    for (genvar k = 0; k < DIV_STAGES; k++)
    begin : g_div
        logic [NUM_W-1:0] rem_nx [CH_N];
        logic [QUO_W-1:0] quo_nx [CH_N];

        always_comb
        begin
            for (int c = 0; c < CH_N; c++)
            begin
                logic [NUM_W-1:0] rem;
                logic [QUO_W-1:0] quo;
                logic [NUM_W-1:0] trial;
                logic [2:0]       bit_idx;
                rem = drem_reg[k][c];
                quo = dquo_reg[k][c];
                for (int j = 0; j < DIV_BITS; j++)
                begin
                    bit_idx = 3'(QUO_W - 1 - k * DIV_BITS - j);
                    trial   = NUM_W'(da0_reg[k]) << bit_idx;
                    if (rem >= trial)
                    begin
                        rem          = rem - trial;
                        quo[bit_idx] = 1'b1;
                    end
                end
                rem_nx[c] = rem;
                quo_nx[c] = quo;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_reg[k+1] <= 1'b0;
            end
            else
            begin
                dv_reg[k+1] <= dv_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (dv_reg[k])
            begin
                dover_reg[k+1]  <= dover_reg[k];
                dearly_reg[k+1] <= dearly_reg[k];
                da0_reg[k+1]    <= da0_reg[k];
                for (int c = 0; c < CH_N; c++)
                begin
                    drem_reg[k+1][c] <= rem_nx[c];
                    dquo_reg[k+1][c] <= quo_nx[c];
                end
            end
        end
    end

    always_comb
    begin
        if (dover_reg[DIV_STAGES])
        begin
            out_pixel_next = {da0_reg[DIV_STAGES], dquo_reg[DIV_STAGES][0],
                              dquo_reg[DIV_STAGES][1], dquo_reg[DIV_STAGES][2]};
        end
        else
        begin
            out_pixel_next = dearly_reg[DIV_STAGES];
        end
    end

    assign done      = done_reg;
    assign out_pixel = out_pixel_reg;

endmodule

// ===== hw/rtl/apac_checker.sv =====
// port-level checker for argb_pixel_alpha_composite_top, bound to the top level
// depends on apac_pkg and argb_pixel_alpha_composite_top_defines.svh
`include "argb_pixel_alpha_composite_top_defines.svh"

module apac_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done
);
    import apac_pkg::*;

    // every taken item comes out after the fixed pipe depth
    `APAC_ASSERT_IMPLY(a_item_delivered, start && !busy, ##PIPE_LATENCY done)

    // no result without an item taken at the matching edge
    `APAC_ASSERT_IMPLY(a_result_has_item, done, $past(start && !busy, PIPE_LATENCY))

    // the pipe is empty right after reset
    `APAC_ASSERT_NEXT(a_empty_after_reset, busy, !done)

endmodule

bind argb_pixel_alpha_composite_top apac_checker u_apac_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done)
);
